// ===== hw/rtl/aes_pkg.sv =====
// aes package: payload types, sbox functions and round helpers
`timescale 1ns / 1ps
package aes_pkg;

    localparam int unsigned BLOCK_W = 128;
    localparam int unsigned ROUND_COUNT = 10;

    typedef struct packed {
        logic        cmd;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_item_t;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam logic [7:0] RED_POLY = 8'h1b;
    localparam logic [7:0] AFF_CONST = 8'h63;

    // multiply by x in gf(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = a[7] ? ((a << 1) ^ RED_POLY) : (a << 1);
    endfunction

    // general gf(2^8) multiply
    function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] p;
        acc = '0;
        p = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc = acc ^ p;
            p = xtime(p);
        end
        fmul = acc;
    endfunction

    // forward sbox table
    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // inverse sbox table
    localparam logic [7:0] ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // sbox lookup on a 32-bit word
    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// ===== hw/rtl/aes_key_sched.sv =====
// aes key schedule: one round-key word per cycle into a 44-entry memory
`timescale 1ns / 1ps
module aes_key_sched
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         build,
    input  logic [127:0] key,
    input  logic [5:0]   rd_addr,
    output logic [31:0]  rd_data,
    output logic         done
);
    import aes_pkg::*;

    localparam int unsigned WORDS = 4 * (ROUND_COUNT + 1);

    logic [31:0] mem [WORDS];
    logic [5:0]  idx_reg, idx_next;
    logic        run_reg, run_next;
    logic [7:0]  rc_reg, rc_next;
    logic [31:0] win_reg [4];
    logic [31:0] t_word;
    logic [31:0] new_word;

    // next word from the last four words in the window
    always_comb
    begin
        t_word = win_reg[3];
        if (idx_reg[1:0] == 2'd0)
            t_word = sub_word({win_reg[3][23:0], win_reg[3][31:24]}) ^ {rc_reg, 24'h0};
        new_word = (idx_reg < 6'd4) ? key[127 - 32 * idx_reg[1:0] -: 32] : (win_reg[0] ^ t_word);
    end

    // sequencer
    always_comb
    begin
        idx_next = idx_reg;
        run_next = run_reg;
        rc_next  = rc_reg;
        if (build && !run_reg)
        begin
            run_next = 1'b1;
            idx_next = '0;
            rc_next  = 8'h01;
        end
        else if (run_reg)
        begin
            idx_next = idx_reg + 6'd1;
            if (idx_reg >= 6'd4 && idx_reg[1:0] == 2'd0)
                rc_next = xtime(rc_reg);
            if (idx_reg == 6'(WORDS - 1))
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            run_reg <= 1'b0;
            rc_reg  <= 8'h01;
        end
        else
        begin
            idx_reg <= idx_next;
            run_reg <= run_next;
            rc_reg  <= rc_next;
        end
    end

    // word window and memory write
    always_ff @(posedge clk)
    begin
        if (run_reg)
        begin
            mem[idx_reg] <= new_word;
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= win_reg[3];
            win_reg[3] <= new_word;
        end
        rd_data <= mem[rd_addr];
    end

    assign done = run_reg && (idx_reg == 6'(WORDS - 1));
endmodule

// ===== hw/rtl/aes_round_unit.sv =====
// aes round unit: one shared forward or inverse round per call
`timescale 1ns / 1ps
module aes_round_unit
(
    input  logic [127:0] state_in,
    input  logic [127:0] rkey,
    input  logic         decrypt,
    input  logic         first,
    input  logic         last,
    output logic [127:0] state_out
);
    import aes_pkg::*;

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] u [16];
    logic [7:0] k [16];
    logic [7:0] m [16];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state_in[127 - 8 * i -: 8];
            k[i] = rkey[127 - 8 * i -: 8];
        end
        // shift rows and substitute bytes
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (decrypt)
                    t[r + 4 * c] = ISBOX[s[r + 4 * ((c + 4 - r) % 4)]];
                else
                    t[r + 4 * c] = SBOX[s[r + 4 * ((c + r) % 4)]];
        if (first)
            for (int i = 0; i < 16; i++)
                t[i] = s[i];
        // encrypt mixes before key, decrypt adds key first
        for (int i = 0; i < 16; i++)
            u[i] = decrypt ? (t[i] ^ k[i]) : t[i];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                if (decrypt)
                    m[4 * c + r] = fmul(u[4 * c + r], 8'd14) ^
                        fmul(u[4 * c + (r + 1) % 4], 8'd11) ^
                        fmul(u[4 * c + (r + 2) % 4], 8'd13) ^
                        fmul(u[4 * c + (r + 3) % 4], 8'd9);
                else
                    m[4 * c + r] = xtime(u[4 * c + r]) ^
                        xtime(u[4 * c + (r + 1) % 4]) ^ u[4 * c + (r + 1) % 4] ^
                        u[4 * c + (r + 2) % 4] ^ u[4 * c + (r + 3) % 4];
        if (last || first)
            for (int i = 0; i < 16; i++)
                m[i] = u[i];
        for (int i = 0; i < 16; i++)
            state_out[127 - 8 * i -: 8] = decrypt ? m[i] : (m[i] ^ k[i]);
    end
endmodule

// ===== hw/rtl/aes128_block_cipher_core.sv =====
// aes-128 core top level: apb key registers, schedule builder, iterative rounds
// channel   | signals                     | transfer
// input     | start, busy, request        | start high and busy low
// result    | done, response              | done high for one cycle
// config    | psel penable pwrite paddr   | access phase, pready tied high
// busy stays high through eleven key additions per item, each with four
// registered round-key reads and one round step; the single-read schedule memory sets this
// done follows in the next cycle, with busy already low
// after a key write the first item also waits for the schedule build
// reset clears key registers and forces a schedule build
// the receiver cannot stall; done lasts one cycle
`timescale 1ns / 1ps
module aes128_block_cipher_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  aes_pkg::in_item_t   request,
    output logic                done,
    output aes_pkg::out_item_t  response,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:3]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    import aes_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_KEY   = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_ROUND = 4'b1000
    } state_t;

    localparam logic ADDR_KEY_HIGH = 1'b0;
    localparam logic ADDR_KEY_LOW  = 1'b1;

    state_t       st_reg, st_next;
    logic [63:0]  key_hi_reg, key_lo_reg;
    logic         sched_ok_reg, sched_ok_next;
    logic         dec_reg, dec_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [127:0] blk_reg, blk_next;
    logic [31:0]  rk_reg [3];
    logic [1:0]   wsel_reg, wsel_next;
    logic [5:0]   rd_addr;
    logic [31:0]  rd_data;
    logic         ks_build, ks_done;
    logic [127:0] round_out;
    logic         wr;
    logic         done_reg;
    logic [3:0]   key_round;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == ADDR_KEY_LOW) ? key_lo_reg : key_hi_reg;

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end
        else if (wr)
        begin
            if (paddr[3] == ADDR_KEY_HIGH)
                key_hi_reg <= pwdata;
            else
                key_lo_reg <= pwdata;
        end
    end

    aes_key_sched u_sched (
        .clk     (clk),
        .rst_n   (rst_n),
        .build   (ks_build),
        .key     ({key_hi_reg, key_lo_reg}),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .done    (ks_done)
    );

    // round key index used by the round being fetched
    assign key_round = dec_reg ? (4'(ROUND_COUNT) - rnd_reg) : rnd_reg;
    assign rd_addr = 6'({key_round, wsel_reg});
    assign ks_build = (st_reg == ST_KEY) && !ks_done && !sched_ok_reg;

    // last word of the round key comes straight from the memory read
    aes_round_unit u_round (
        .state_in  (blk_reg),
        .rkey      ({rk_reg[0], rk_reg[1], rk_reg[2], rd_data}),
        .decrypt   (dec_reg),
        .first     (rnd_reg == 4'd0),
        .last      (rnd_reg == 4'(ROUND_COUNT)),
        .state_out (round_out)
    );

    // sequencer
    always_comb
    begin
        st_next = st_reg;
        sched_ok_next = sched_ok_reg;
        dec_next = dec_reg;
        rnd_next = rnd_reg;
        blk_next = blk_reg;
        wsel_next = wsel_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    dec_next = request.cmd;
                    blk_next = {request.block_high, request.block_low};
                    rnd_next = '0;
                    wsel_next = '0;
                    st_next = sched_ok_reg ? ST_FETCH : ST_KEY;
                end
            end
            ST_KEY:
            begin
                if (ks_done)
                begin
                    sched_ok_next = 1'b1;
                    st_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                // four reads, the data of each lands in the next cycle
                wsel_next = wsel_reg + 2'd1;
                if (wsel_reg == 2'd3)
                    st_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                blk_next = round_out;
                wsel_next = '0;
                if (rnd_reg == 4'(ROUND_COUNT))
                    st_next = ST_IDLE;
                else
                begin
                    rnd_next = rnd_reg + 4'd1;
                    st_next = ST_FETCH;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
        if (wr)
            sched_ok_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            sched_ok_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg <= '0;
            wsel_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            sched_ok_reg <= sched_ok_next;
            done_reg <= (st_reg == ST_ROUND) && (rnd_reg == 4'(ROUND_COUNT));
            rnd_reg <= rnd_next;
            wsel_reg <= wsel_next;
        end
    end

    // payload registers and round key capture
    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
        blk_reg <= blk_next;
        if (st_reg == ST_FETCH)
        begin
            rk_reg[0] <= rk_reg[1];
            rk_reg[1] <= rk_reg[2];
            rk_reg[2] <= rd_data;
        end
    end

    assign busy = (st_reg != ST_IDLE);
    assign done = done_reg;
    assign response.result_high = blk_reg[127:64];
    assign response.result_low = blk_reg[63:0];
endmodule

// ===== hw/rtl/aes_core_checker.sv =====
// aes core port checker and its bind
`timescale 1ns / 1ps
module aes_core_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic pready
);
    // an accepted item makes the core busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("item not taken");

    // result strobe is one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");

    // result comes only once work is over
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");

    // busy ends with a result
    a_busy_fell: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done) else $error("busy dropped without result");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready) else $error("pready low");
endmodule

bind aes128_block_cipher_core aes_core_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .pready (pready)
);

// ===== test/aes128_block_cipher_checker.sv =====
// checker for the aes-128 core: tracks the key, predicts every block and compares results
`timescale 1ns / 1ps
module aes128_block_cipher_checker #(
    parameter logic [3:3] KEY_HIGH_ADDR = 1'b0,
    parameter logic [3:3] KEY_LOW_ADDR = 1'b1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  aes_pkg::in_item_t   request,
    input  logic                done,
    input  aes_pkg::out_item_t  response,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [3:3]          paddr,
    input  logic [63:0]         pwdata,
    output int                  mismatch_count,
    output int                  blocks_pending,
    output int                  blocks_checked
);
    import aes_pkg::*;

    logic [7:0]  fwd_sbox [256];
    logic [7:0]  rev_sbox [256];
    logic [63:0] key_high_q;
    logic [63:0] key_low_q;
    logic [31:0] key_words [44];
    bit          schedule_ok;
    out_item_t   expected_blocks [$];

    // gf(2^8) multiply with the aes reduction polynomial
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc = acc ^ a;
            a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
        end
        return acc;
    endfunction

    // sbox tables from the field inverse and the affine map
    initial
    begin
        logic [7:0] inv_val;
        logic [7:0] pw;
        logic [7:0] s;
        for (int i = 0; i < 256; i++)
        begin
            inv_val = 8'h01;
            pw = i[7:0];
            for (int e = 254; e != 0; e = e >> 1)
            begin
                if (e & 1)
                    inv_val = gf_mul(inv_val, pw);
                pw = gf_mul(pw, pw);
            end
            s = inv_val ^ {inv_val[6:0], inv_val[7]} ^ {inv_val[5:0], inv_val[7:6]}
                ^ {inv_val[4:0], inv_val[7:5]} ^ {inv_val[3:0], inv_val[7:4]} ^ 8'h63;
            fwd_sbox[i] = s;
            rev_sbox[s] = i[7:0];
        end
    end

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
    endfunction

    // key expansion into 44 words
    function automatic void build_schedule();
        logic [31:0] t;
        logic [7:0]  rcon;
        rcon = 8'h01;
        key_words[0] = key_high_q[63:32];
        key_words[1] = key_high_q[31:0];
        key_words[2] = key_low_q[63:32];
        key_words[3] = key_low_q[31:0];
        for (int i = 4; i < 44; i++)
        begin
            t = key_words[i-1];
            if (i % 4 == 0)
            begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = gf_mul(rcon, 8'h02);
            end
            key_words[i] = key_words[i-4] ^ t;
        end
        schedule_ok = 1'b1;
    endfunction

    // byte i of the state sits at bits 127-8i down
    function automatic logic [127:0] xor_key(input logic [127:0] st, input int rnd);
        return st ^ {key_words[4*rnd], key_words[4*rnd+1],
                     key_words[4*rnd+2], key_words[4*rnd+3]};
    endfunction

    function automatic logic [127:0] byte_sub(input logic [127:0] st, input bit inverse);
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
            r[127-8*i -: 8] = inverse ? rev_sbox[st[127-8*i -: 8]] : fwd_sbox[st[127-8*i -: 8]];
        return r;
    endfunction

    // row r rotates left by r, right when inverse
    function automatic logic [127:0] row_rotate(input logic [127:0] st, input bit inverse);
        logic [127:0] r;
        int src;
        for (int row = 0; row < 4; row++)
            for (int c = 0; c < 4; c++)
            begin
                src = inverse ? ((c + 4 - row) & 3) : ((c + row) & 3);
                r[127-8*(row+4*c) -: 8] = st[127-8*(row+4*src) -: 8];
            end
        return r;
    endfunction

    function automatic logic [127:0] column_mix(input logic [127:0] st, input bit inverse);
        logic [7:0]   coef [4];
        logic [7:0]   v;
        logic [127:0] r;
        if (inverse)
            coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else
            coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
            for (int row = 0; row < 4; row++)
            begin
                v = '0;
                for (int k = 0; k < 4; k++)
                    v = v ^ gf_mul(st[127-8*(4*c+k) -: 8], coef[(k + 4 - row) & 3]);
                r[127-8*(4*c+row) -: 8] = v;
            end
        return r;
    endfunction

    // ten-round cipher in either direction
    function automatic out_item_t cipher_block(input in_item_t it);
        logic [127:0] st;
        out_item_t    res;
        st = {it.block_high, it.block_low};
        if (it.cmd == CMD_ENCRYPT)
        begin
            st = xor_key(st, 0);
            for (int rnd = 1; rnd < 10; rnd++)
                st = xor_key(column_mix(row_rotate(byte_sub(st, 0), 0), 0), rnd);
            st = xor_key(row_rotate(byte_sub(st, 0), 0), 10);
        end
        else
        begin
            st = xor_key(st, 10);
            for (int rnd = 9; rnd > 0; rnd--)
                st = column_mix(xor_key(byte_sub(row_rotate(st, 1), 1), rnd), 1);
            st = xor_key(byte_sub(row_rotate(st, 1), 1), 0);
        end
        res.result_high = st[127:64];
        res.result_low = st[63:0];
        return res;
    endfunction

    // watch key writes, block transfers and results
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            key_high_q = '0;
            key_low_q = '0;
            schedule_ok = 1'b0;
            expected_blocks.delete();
            mismatch_count = 0;
            blocks_checked = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == KEY_HIGH_ADDR)
                    key_high_q = pwdata;
                else if (paddr == KEY_LOW_ADDR)
                    key_low_q = pwdata;
                schedule_ok = 1'b0;
            end
            if (start && !busy)
            begin
                if (!schedule_ok)
                    build_schedule();
                expected_blocks.push_back(cipher_block(request));
            end
            if (done)
            begin
                if (expected_blocks.size() == 0)
                begin
                    $error("result %h_%h with no block outstanding",
                           response.result_high, response.result_low);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    blocks_checked++;
                    if (response.result_high !== want.result_high)
                    begin
                        $error("result_high expected %h actual %h",
                               want.result_high, response.result_high);
                        mismatch_count++;
                    end
                    if (response.result_low !== want.result_low)
                    begin
                        $error("result_low expected %h actual %h",
                               want.result_low, response.result_low);
                        mismatch_count++;
                    end
                end
            end
        end
        blocks_pending = expected_blocks.size();
    end

endmodule

// ===== test/tb.sv =====
// testbench top for the aes-128 core: clock, reset, key writes, block stimulus, verdict
`timescale 1ns / 1ps
module tb;
    import aes_pkg::*;

    localparam logic [3:3] KEY_HIGH_ADDR = 1'b0;
    localparam logic [3:3] KEY_LOW_ADDR = 1'b1;
    localparam int WATCHDOG_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    request;
    logic        done;
    out_item_t   response;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:3]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    int          mismatch_count;
    int          blocks_pending;
    int          blocks_checked;
    int          quiet_cycles;
    int          key_settings;

    aes128_block_cipher_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .response(response),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    aes128_block_cipher_checker #(
        .KEY_HIGH_ADDR(KEY_HIGH_ADDR),
        .KEY_LOW_ADDR (KEY_LOW_ADDR)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .done          (done),
        .response      (response),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatch_count(mismatch_count),
        .blocks_pending(blocks_pending),
        .blocks_checked(blocks_checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog on cycles with no transfer of any kind
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d blocks pending", blocks_pending);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // random 64-bit value with the extremes mixed in
    function automatic logic [63:0] rand_word();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // stop sending and wait for every outstanding block
    task automatic drain_blocks();
        start <= 1'b0;
        do @(negedge clk); while (blocks_pending != 0);
        @(posedge clk);
    endtask

    // one apb write, only while the core is idle
    task automatic write_key_reg(input logic [3:3] addr, input logic [63:0] value);
        drain_blocks();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
        write_key_reg(KEY_HIGH_ADDR, hi);
        write_key_reg(KEY_LOW_ADDR, lo);
        key_settings++;
    endtask

    // one block transfer, with a random gap ahead of it; start stays high afterwards
    task automatic send_block(input logic cmd, input logic [63:0] hi, input logic [63:0] lo,
                              input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        request <= '{cmd: cmd, block_high: hi, block_low: lo};
        do @(negedge clk); while (busy);
        @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int idle_pct;
        quiet_cycles = 0;
        key_settings = 1;
        rst_n = 1'b0;
        start <= 1'b0;
        request <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= KEY_HIGH_ADDR;
        pwdata <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key of all zeros, before any write
        send_block(CMD_ENCRYPT, '0, '0, 0);
        send_block(CMD_DECRYPT, '0, '0, 0);
        send_block(CMD_ENCRYPT, '1, '1, 0);
        send_block(CMD_DECRYPT, '1, '1, 0);

        // standard known-answer key and block
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 0);
        send_block(CMD_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 0);
        send_block(CMD_ENCRYPT, '0, '1, 0);

        // all-ones key
        load_key('1, '1);
        send_block(CMD_ENCRYPT, '0, '0, 0);
        send_block(CMD_DECRYPT, '1, '0, 0);
        send_block(CMD_ENCRYPT, '1, '1, 0);

        // a single register change rebuilds the schedule too
        write_key_reg(KEY_HIGH_ADDR, 64'h8000000000000001);
        key_settings++;
        send_block(CMD_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001, 0);
        send_block(CMD_DECRYPT, 64'h0000000000000001, 64'h8000000000000000, 0);

        // random phases, new key for each, varying sender gaps
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: load_key('0, '0);
                1: load_key('1, '1);
                default: load_key(rand_word(), rand_word());
            endcase
            case (phase % 3)
                0: idle_pct = 0;
                1: idle_pct = 62;
                default: idle_pct = 27;
            endcase
            for (int n = 0; n < 237; n++)
                send_block(1'($urandom_range(1)), rand_word(), rand_word(), idle_pct);
            drain_blocks();
        end

        drain_blocks();
        repeat (20) @(posedge clk);
        $display("checked %0d blocks in both directions over %0d key settings", blocks_checked,
                 key_settings);
        $display("sender gaps of 0, 27 and 62 percent, key writes only with the core idle");
        if (mismatch_count == 0 && blocks_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
